// ----- sv/four_level_page_table_walker_macros.svh -----
// Assertion macros used by the checker file.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptw assertion failed");

`endif

// ----- sv/ptw_pkg.sv -----
`default_nettype none
package ptw_pkg;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_NOTPRES = 2'd2,
        KIND_OUTSIDE = 2'd3
    } resp_kind_t;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    localparam logic [15:0] KERNEL_TOP = 16'hffff;
    localparam int          PRESENT_BIT = 0;
    localparam int          LARGE_BIT   = 7;

    // Only root address bits 51:12 and entry data bits 51:0 are kept past the input port.
    typedef struct packed {
        logic        req_type;
        logic [63:0] virt_addr;
        logic [39:0] root_frame;
        logic        kernel_only;
        logic [51:0] entry_data;
    } in_item_t;

    typedef struct packed {
        resp_kind_t  resp_kind;
        logic [51:0] read_addr;
        logic [39:0] frame_number;
        logic        large_page;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/four_level_page_table_walker.sv -----
// Channel  Direction  Word
// s_       in         req_type, virt_addr, root_addr, kernel_only, entry_data
// m_       out        resp_kind, read_addr, frame_number, large_page
//
// Each word is held in the input register and its result then in the result
// register; the result is loaded as the word leaves the input register, which
// waits while the result register is stalled.
// One word is taken per cycle while s_ready is high; the walk state updates as a word leaves the input
// register. An entry response while no walk is active gives no result.
// Reset (aresetn low at a clock edge) empties both registers and ends any walk.
// A stalled result register holds the input register, which then lowers s_ready.
`default_nettype none
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [63:0] s_virt_addr,
    input  wire logic [63:0] s_root_addr,
    input  wire logic        s_kernel_only,
    input  wire logic [63:0] s_entry_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_resp_kind,
    output logic [51:0]      m_read_addr,
    output logic [39:0]      m_frame_number,
    output logic             m_large_page
);

    logic     item_valid;
    in_item_t item;
    logic     advance;
    logic     out_free;
    logic     has_result;
    result_t  result;

    assign advance = item_valid && out_free;

    ptw_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_virt_addr   (s_virt_addr),
        .s_root_addr   (s_root_addr),
        .s_kernel_only (s_kernel_only),
        .s_entry_data  (s_entry_data),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    ptw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    ptw_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && has_result),
        .result         (result),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_resp_kind    (m_resp_kind),
        .m_read_addr    (m_read_addr),
        .m_frame_number (m_frame_number),
        .m_large_page   (m_large_page)
    );

endmodule
`default_nettype wire

// ----- sv/ptw_in_stage.sv -----
`default_nettype none
module ptw_in_stage
    import ptw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [63:0] s_virt_addr,
    input  wire logic [63:0] s_root_addr,
    input  wire logic        s_kernel_only,
    input  wire logic [63:0] s_entry_data,
    input  wire logic        advance,
    output logic             item_valid,
    output in_item_t         item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The register may refill in the same cycle that it hands its word on.
    assign s_ready    = !valid_reg || advance;
    assign accept     = s_valid && s_ready;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.req_type    <= s_req_type;
            item_reg.virt_addr   <= s_virt_addr;
            item_reg.root_frame  <= s_root_addr[51:12];
            item_reg.kernel_only <= s_kernel_only;
            item_reg.entry_data  <= s_entry_data[51:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ----- sv/ptw_walk.sv -----
`default_nettype none
module ptw_walk
    import ptw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     item_valid,
    input  wire in_item_t item,
    input  wire logic     advance,
    output logic          has_result,
    output result_t       result
);

    logic        walking_reg;
    logic        walking_next;
    logic [1:0]  levels_left_reg;
    logic [1:0]  levels_left_next;
    logic [47:0] saved_virt_reg;
    logic [47:0] saved_virt_next;
    logic [51:0] entry_addr_reg;
    logic [51:0] entry_addr_next;

    logic [1:0]  next_left;
    logic [8:0]  next_index;
    logic [39:0] entry_frame;

    assign entry_frame = item.entry_data[51:12];
    assign next_left   = levels_left_reg - 2'd1;

    always_comb begin
        unique case (next_left)
            2'd3:    next_index = saved_virt_reg[47:39];
            2'd2:    next_index = saved_virt_reg[38:30];
            2'd1:    next_index = saved_virt_reg[29:21];
            default: next_index = saved_virt_reg[20:12];
        endcase
    end

    always_comb begin
        walking_next     = walking_reg;
        levels_left_next = levels_left_reg;
        saved_virt_next  = saved_virt_reg;
        entry_addr_next  = entry_addr_reg;
        has_result       = 1'b0;
        result           = '{resp_kind: KIND_READ, read_addr: '0,
                             frame_number: '0, large_page: 1'b0};

        if (item.req_type == REQ_START) begin
            has_result = 1'b1;
            if (item.kernel_only && item.virt_addr[63:48] != KERNEL_TOP) begin
                walking_next     = 1'b0;
                result.resp_kind = KIND_OUTSIDE;
            end else begin
                // The table base is page aligned, so the entry offset only fills
                // the low twelve bits and needs no adder.
                walking_next     = 1'b1;
                levels_left_next = 2'd3;
                saved_virt_next  = item.virt_addr[47:0];
                entry_addr_next  = {item.root_frame, item.virt_addr[47:39], 3'b000};
                result.read_addr = entry_addr_next;
            end
        end else if (walking_reg) begin
            has_result = 1'b1;
            if (!item.entry_data[PRESENT_BIT]) begin
                walking_next     = 1'b0;
                result.resp_kind = KIND_NOTPRES;
            end else if (levels_left_reg == 2'd1 && item.entry_data[LARGE_BIT]) begin
                walking_next        = 1'b0;
                result.resp_kind    = KIND_DONE;
                result.frame_number = {entry_frame[39:9], saved_virt_reg[20:12]};
                result.large_page   = 1'b1;
            end else if (levels_left_reg == 2'd0) begin
                walking_next        = 1'b0;
                result.resp_kind    = KIND_DONE;
                result.frame_number = entry_frame;
            end else begin
                levels_left_next = next_left;
                entry_addr_next  = {entry_frame, next_index, 3'b000};
                result.read_addr = entry_addr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walking_reg     <= 1'b0;
            levels_left_reg <= 2'd0;
            saved_virt_reg  <= '0;
            entry_addr_reg  <= '0;
        end else if (item_valid && advance) begin
            walking_reg     <= walking_next;
            levels_left_reg <= levels_left_next;
            saved_virt_reg  <= saved_virt_next;
            entry_addr_reg  <= entry_addr_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/ptw_out_stage.sv -----
`default_nettype none
module ptw_out_stage
    import ptw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire result_t     result,
    output logic             out_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_resp_kind,
    output logic [51:0]      m_read_addr,
    output logic [39:0]      m_frame_number,
    output logic             m_large_page
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_resp_kind    = result_reg.resp_kind;
    assign m_read_addr    = result_reg.read_addr;
    assign m_frame_number = result_reg.frame_number;
    assign m_large_page   = result_reg.large_page;

endmodule
`default_nettype wire

// ----- sv/ptw_checker.sv -----
`default_nettype none
`include "four_level_page_table_walker_macros.svh"
module ptw_checker
    import ptw_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_resp_kind,
    input wire logic [51:0] m_read_addr,
    input wire logic [39:0] m_frame_number,
    input wire logic        m_large_page
);

    // A waiting result word must stay valid and keep its kind, read address and frame number under a stall.
    `PTW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_resp_kind) && $stable(m_read_addr) && $stable(m_frame_number))

    // Only a read request carries an address, and it is always entry aligned.
    `PTW_ASSERT_IMPLY(a_addr_zero, aclk, aresetn, m_valid && m_resp_kind != KIND_READ, m_read_addr == 52'd0)
    `PTW_ASSERT_IMPLY(a_addr_align, aclk, aresetn, m_valid && m_resp_kind == KIND_READ, m_read_addr[2:0] == 3'd0)

    // Only a completed walk carries a frame or the large page flag.
    `PTW_ASSERT_IMPLY(a_frame_zero, aclk, aresetn, m_valid && m_resp_kind != KIND_DONE, m_frame_number == 40'd0 && !m_large_page)

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_resp_kind    (m_resp_kind),
    .m_read_addr    (m_read_addr),
    .m_frame_number (m_frame_number),
    .m_large_page   (m_large_page)
);
`default_nettype wire
